@@ sv/swam_pkg.sv @@
// swam_pkg: shared types and codes for the sliding window anagram matcher
// depends on nothing; used by every module of the block by scoped names
package swam_pkg;

	localparam int LETTER_W = 5;
	localparam int ACTION_W = 2;

	// action codes
	localparam logic [ACTION_W-1:0] ACT_CLEAR   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_PATTERN = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_TEXT    = 2'd2;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [LETTER_W-1:0] letter;
	} item_t;

	typedef struct packed {
		logic window_match;
		logic found;
		logic pattern_overflow;
	} result_t;

	// state update for one accepted item, already gated by the stage advance
	typedef struct packed {
		logic clear;
		logic pat_add;
		logic txt_add;
		logic evict;
	} upd_t;

endpackage

@@ sv/sliding_window_anagram_match.sv @@
// sliding_window_anagram_match: top level, handshakes, control and result register
// depends on swam_pkg, swam_counts, swam_ring
//
// Streams letters and reports, for every item, whether the window of
// pattern length ending at the current text letter is a rearrangement of
// the pattern, plus sticky found and pattern overflow flags. A clear item
// resets everything, pattern items add letters to the pattern (letters
// past PATTERN_MAX are dropped and flagged), text items slide the window.
// An empty pattern matches every text letter. Letters at or above
// ALPHABET_SIZE and unused action codes leave state alone and report no
// match. One item is taken every clock cycle while results are taken;
// each item is held in the input register, where the counter
// update and the parallel per-letter compare happen, and then leaves
// through the result register. The full rate comes from the ring
// memory whose oldest entry is read ahead into a register, with
// forwarding when the slot being written is the one needed next. The
// ring memory needs no clearing pass: only entries written since the
// last clear are read.
module sliding_window_anagram_match #(
	parameter int PATTERN_MAX   = 64,
	parameter int ALPHABET_SIZE = 26
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  swam_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output swam_pkg::result_t result
);

	// counters reach PATTERN_MAX itself
	localparam int CNT_W = $clog2(PATTERN_MAX + 1);
	localparam int PAD_W = 32 - swam_pkg::LETTER_W;
	localparam logic [CNT_W-1:0] PAT_FULL = CNT_W'(PATTERN_MAX);

	// input register
	logic              s1_valid_q;
	swam_pkg::item_t   item_s1;
	logic              adv;

	// block state
	logic [CNT_W-1:0]  pat_size_q;
	logic [CNT_W-1:0]  fill_q;
	logic              found_q;
	logic              ovf_q;

	// result register
	logic              out_valid_q;
	swam_pkg::result_t out_q;

	// decode of the item in the input register
	logic              letter_ok;
	logic              is_clear;
	logic              is_pat;
	logic              is_txt;
	logic              pat_full;
	logic              pat_empty;
	logic              txt_take;
	logic              evict;
	logic [CNT_W-1:0]  fill_nx;
	logic              counts_equal;
	logic              match;
	logic              found_nx;
	logic              ovf_nx;
	swam_pkg::upd_t    upd;
	logic [swam_pkg::LETTER_W-1:0] oldest;

	// stage moves on when the result register is empty or being emptied
	assign adv        = s1_valid_q && (!out_valid_q || result_ready);
	assign item_ready = !s1_valid_q || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (item_ready) begin
			s1_valid_q <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready)
			item_s1 <= item;
	end

	always_comb begin
		letter_ok = ({{PAD_W{1'b0}}, item_s1.letter} < 32'(ALPHABET_SIZE));
		is_clear  = (item_s1.action == swam_pkg::ACT_CLEAR);
		is_pat    = (item_s1.action == swam_pkg::ACT_PATTERN) && letter_ok;
		is_txt    = (item_s1.action == swam_pkg::ACT_TEXT) && letter_ok;
		pat_full  = (pat_size_q >= PAT_FULL);
		pat_empty = (pat_size_q == '0);
		// empty pattern: text letter matches but never enters the window
		txt_take  = is_txt && !pat_empty;
		evict     = txt_take && (fill_q >= pat_size_q);
		fill_nx   = fill_q + CNT_W'(txt_take && !evict);
		match     = is_txt && (pat_empty || ((fill_nx == pat_size_q) && counts_equal));
		found_nx  = !is_clear && (found_q || match);
		ovf_nx    = !is_clear && (ovf_q || (is_pat && pat_full));
	end

	// all state updates are gated by the stage advance
	always_comb begin
		upd.clear   = adv && is_clear;
		upd.pat_add = adv && is_pat && !pat_full;
		upd.txt_add = adv && txt_take;
		upd.evict   = adv && evict;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_size_q <= '0;
			fill_q     <= '0;
			found_q    <= 1'b0;
			ovf_q      <= 1'b0;
		end else if (adv) begin
			if (is_clear) begin
				pat_size_q <= '0;
				fill_q     <= '0;
			end else begin
				pat_size_q <= pat_size_q + CNT_W'(is_pat && !pat_full);
				fill_q     <= fill_nx;
			end
			found_q <= found_nx;
			ovf_q   <= ovf_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.window_match     <= match;
			out_q.found            <= found_nx;
			out_q.pattern_overflow <= ovf_nx;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	swam_counts #(
		.ALPHABET_SIZE (ALPHABET_SIZE),
		.CNT_W         (CNT_W)
	) u_counts (
		.clk          (clk),
		.arst_n       (arst_n),
		.upd          (upd),
		.letter       (item_s1.letter),
		.oldest       (oldest),
		.counts_equal (counts_equal)
	);

	swam_ring #(
		.PATTERN_MAX (PATTERN_MAX)
	) u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (upd),
		.letter (item_s1.letter),
		.oldest (oldest)
	);

endmodule

@@ sv/swam_counts.sv @@
// swam_counts: per-letter pattern and window counters with the parallel compare
// depends on swam_pkg
module swam_counts #(
	parameter int ALPHABET_SIZE = 26,
	parameter int CNT_W         = 7
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  swam_pkg::upd_t                upd,
	input  logic [swam_pkg::LETTER_W-1:0] letter,
	input  logic [swam_pkg::LETTER_W-1:0] oldest,
	output logic                          counts_equal
);

	localparam int PAD_W = 32 - swam_pkg::LETTER_W;

	logic [CNT_W-1:0]         pat_cnt_q [ALPHABET_SIZE];
	logic [CNT_W-1:0]         win_cnt_q [ALPHABET_SIZE];
	logic [ALPHABET_SIZE-1:0] lane_eq;
	logic [31:0]              letter_x;
	logic [31:0]              oldest_x;

	assign letter_x = {{PAD_W{1'b0}}, letter};
	assign oldest_x = {{PAD_W{1'b0}}, oldest};

	for (genvar k = 0; k < ALPHABET_SIZE; k++) begin : g_lane
		logic             hit_new;
		logic             hit_old;
		logic [CNT_W-1:0] win_nx;
		logic [CNT_W-1:0] pat_nx;

		assign hit_new = (letter_x == 32'(k));
		assign hit_old = (oldest_x == 32'(k));

		always_comb begin
			win_nx = win_cnt_q[k] + CNT_W'(upd.txt_add && hit_new)
				- CNT_W'(upd.evict && hit_old);
			pat_nx = pat_cnt_q[k] + CNT_W'(upd.pat_add && hit_new);
		end

		// compare against the window as it stands after this item
		assign lane_eq[k] = (win_nx == pat_cnt_q[k]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pat_cnt_q[k] <= '0;
				win_cnt_q[k] <= '0;
			end else if (upd.clear) begin
				pat_cnt_q[k] <= '0;
				win_cnt_q[k] <= '0;
			end else begin
				pat_cnt_q[k] <= pat_nx;
				win_cnt_q[k] <= win_nx;
			end
		end
	end

	assign counts_equal = &lane_eq;

endmodule

@@ sv/swam_ring.sv @@
// swam_ring: ring memory of recent text letters with write and oldest pointers
// depends on swam_pkg
module swam_ring #(
	parameter int PATTERN_MAX = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  swam_pkg::upd_t                upd,
	input  logic [swam_pkg::LETTER_W-1:0] letter,
	output logic [swam_pkg::LETTER_W-1:0] oldest
);

	localparam int RING_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam logic [RING_W-1:0] RING_LAST = RING_W'(PATTERN_MAX - 1);

	logic [swam_pkg::LETTER_W-1:0] mem [PATTERN_MAX];
	logic [RING_W-1:0]             wr_ptr_q;
	logic [RING_W-1:0]             tail_q;
	logic [RING_W-1:0]             tail_nx;
	logic [RING_W-1:0]             wr_ptr_nx;
	logic [swam_pkg::LETTER_W-1:0] rd_q;

	always_comb begin
		wr_ptr_nx = wr_ptr_q;
		tail_nx   = tail_q;
		if (upd.clear) begin
			wr_ptr_nx = '0;
			tail_nx   = '0;
		end else begin
			if (upd.txt_add)
				wr_ptr_nx = (wr_ptr_q == RING_LAST) ? '0 : wr_ptr_q + 1'b1;
			// tail only moves when the full window drops its oldest letter
			if (upd.evict)
				tail_nx = (tail_q == RING_LAST) ? '0 : tail_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			tail_q   <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_nx;
			tail_q   <= tail_nx;
		end
	end

	// one write port, one registered read port with write forwarding
	always_ff @(posedge clk) begin
		if (upd.txt_add)
			mem[wr_ptr_q] <= letter;
		if (upd.txt_add && (wr_ptr_q == tail_nx))
			rd_q <= letter;
		else
			rd_q <= mem[tail_nx];
	end

	assign oldest = rd_q;

endmodule

@@ sv/swam_checker.sv @@
// swam_checker: port-level checks on the anagram matcher, bound to the top level
// depends on swam_pkg and sliding_window_anagram_match
module swam_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_ready,
	input swam_pkg::item_t   item,
	input logic              result_valid,
	input logic              result_ready,
	input swam_pkg::result_t result
);

	// items in flight: transfers in minus transfers out
	logic [2:0] inflight_q;
	logic       in_xfer;
	logic       out_xfer;

	assign in_xfer  = item_valid && item_ready;
	assign out_xfer = result_valid && result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 3'(in_xfer) - 3'(out_xfer);
		end
	end

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	a_match_sets_found: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.window_match |-> result.found)
		else $error("window match without found flag");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 3'd2)
		else $error("more than two items in flight");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> inflight_q != 3'd0)
		else $error("result with no item in flight");

	a_clear_drops_flags: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && item.action == swam_pkg::ACT_CLEAR && inflight_q == 3'd0
		##1 !result_valid |=> result_valid |-> !result.found && !result.pattern_overflow)
		else $error("flags survived a clear");

endmodule

bind sliding_window_anagram_match swam_checker u_swam_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.item         (item),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
